// ===== design/whd_pkg.sv =====
// ----------------------------------------------------------------------------
// whd_pkg - shared types and constants for the wrapped bin histogram
// Widths, bin count, register indexes and the divider request type.
// ----------------------------------------------------------------------------
`default_nettype none

package whd_pkg;

    // histogram geometry
    localparam int BIN_COUNT = 10;
    localparam int BIN_W     = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;

    // field widths
    localparam int MZ_W      = 40;
    localparam int INT_W     = 32;
    localparam int SUM_W     = 48;
    localparam int BASE_W    = 6;
    localparam int DIGIT_W   = 6;
    localparam int NUM_W     = 6;
    localparam int PROD_W    = BASE_W + SUM_W;

    // stream packing
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 16;

    // shared divider
    localparam int DIV_BITS_W = MZ_W;
    localparam int CNT_W      = 6;
    localparam int QUOT_W     = DIGIT_W;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 40;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH  = 2'd1;

    // register reset values
    localparam logic [BASE_W-1:0] BASE_RESET  = 6'd10;
    localparam logic [MZ_W-1:0]   WIDTH_RESET = 40'd100000000;

    // digit base clamp limits
    localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
    localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;

    // divider start request
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] count;
    } t_div_req;

endpackage

`default_nettype wire

// ===== design/wrapped_bin_histogram_digits.sv =====
// ----------------------------------------------------------------------------
// wrapped_bin_histogram_digits - wrapped bin spectrum histogram digits
// Bins ions by m/z into a wrapped histogram and emits one digit per bin on
// the last ion of a spectrum.
// ----------------------------------------------------------------------------
// Each ion beat is accepted in idle, then worked on one shared restoring
// divider that retires one quotient bit of the 40-bit m/z per cycle and
// raises its done strobe, then written to the bin store with a saturating
// add. On the beat marked tlast, the block then emits BIN_COUNT digit beats;
// each digit is a store read, a 6x48 multiply, a divider start, and six
// divider steps plus the done strobe on the same divider, then the output
// wait. When the histogram is empty the divider steps are skipped and the
// digit is zero. Every bin is cleared as its digit is formed. The input
// side is not ready while an ion or its digits are being worked. The
// configuration channel is always ready and should be written only while
// the block is idle.
`default_nettype none

module wrapped_bin_histogram_digits
    import whd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration write channel
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // ion input stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // mz_micro[39:0], intensity_q[71:40]
    input  wire logic                  s_axis_tlast,   // last_ion
    // digit output stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // bin_digit[5:0], bin_number[11:6], pad
    output logic                       m_axis_tlast    // last_digit
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_BIN    = 8'b0000_0010,
        S_ACC    = 8'b0000_0100,
        S_RDK    = 8'b0000_1000,
        S_MUL    = 8'b0001_0000,
        S_DSTART = 8'b0010_0000,
        S_DWAIT  = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [BASE_W-1:0] r_base;
    logic [MZ_W-1:0]   r_width;

    // per-ion and per-digit registers
    logic [INT_W-1:0]   r_inten;
    logic               r_last;
    logic [BIN_W-1:0]   r_idx;
    logic [BIN_W-1:0]   r_k;
    logic [SUM_W-1:0]   r_largest;
    logic [PROD_W-1:0]  r_prod;
    logic [DIGIT_W-1:0] r_digit;

    // bin store
    logic [SUM_W-1:0]     r_mem [BIN_COUNT];
    logic [BIN_COUNT-1:0] r_valid;
    logic [SUM_W-1:0]     r_rd_data;
    logic                 r_rd_valid;

    // divider hookup
    t_div_req              w_req;
    logic [SUM_W-1:0]      w_rem_init;
    logic [DIV_BITS_W-1:0] w_bits;
    logic [SUM_W-1:0]      w_divisor;
    logic                  w_done;
    logic [QUOT_W-1:0]     w_quot;
    logic [BIN_W-1:0]      w_mod;

    logic              w_in_acc;
    logic              w_out_acc;
    logic [MZ_W-1:0]   w_width_eff;
    logic [BASE_W-1:0] w_scale;
    logic [SUM_W-1:0]  w_rd_eff;
    logic [SUM_W:0]    w_sum_raw;
    logic [SUM_W-1:0]  w_sum;
    logic [BIN_W-1:0]  w_rd_addr;
    logic              w_k_last;

    assign w_in_acc  = s_axis_tvalid & s_axis_tready;
    assign w_out_acc = m_axis_tvalid & m_axis_tready;
    assign w_k_last  = (r_k == BIN_W'(BIN_COUNT - 1));

    // operand conditioning: zero width as one, base clamped, scale = base - 1
    always_comb begin
        w_width_eff = (r_width == '0) ? MZ_W'(1) : r_width;
        if (r_base < BASE_MIN) begin
            w_scale = BASE_MIN - 1'b1;
        end else if (r_base > BASE_MAX) begin
            w_scale = BASE_MAX - 1'b1;
        end else begin
            w_scale = r_base - 1'b1;
        end
    end

    // saturating accumulate
    always_comb begin
        w_rd_eff  = r_rd_valid ? r_rd_data : '0;
        w_sum_raw = {1'b0, w_rd_eff} + (SUM_W+1)'(r_inten);
        w_sum     = w_sum_raw[SUM_W] ? {SUM_W{1'b1}} : w_sum_raw[SUM_W-1:0];
    end

    // divider requests: full m/z division for an ion, six steps for a digit
    always_comb begin
        w_req.start = 1'b0;
        w_req.count = CNT_W'(DIV_BITS_W);
        w_rem_init  = '0;
        w_bits      = s_axis_tdata[MZ_W-1:0];
        w_divisor   = SUM_W'(w_width_eff);
        if (r_state == S_IDLE) begin
            w_req.start = w_in_acc;
        end else begin
            w_req.start = (r_state == S_DSTART) && (r_largest != '0);
            w_req.count = CNT_W'(QUOT_W);
            w_rem_init  = r_prod[PROD_W-1:QUOT_W];
            w_bits      = {r_prod[QUOT_W-1:0], (DIV_BITS_W-QUOT_W)'(0)};
            w_divisor   = r_largest;
        end
    end

    whd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .i_rem_init (w_rem_init),
        .i_bits     (w_bits),
        .i_divisor  (w_divisor),
        .o_done     (w_done),
        .o_quot     (w_quot),
        .o_mod      (w_mod)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_in_acc) n_state = S_BIN;
            S_BIN:    if (w_done) n_state = S_ACC;
            S_ACC:    n_state = r_last ? S_RDK : S_IDLE;
            S_RDK:    n_state = S_MUL;
            S_MUL:    n_state = S_DSTART;
            S_DSTART: n_state = (r_largest == '0) ? S_OUT : S_DWAIT;
            S_DWAIT:  if (w_done) n_state = S_OUT;
            S_OUT: begin
                if (w_out_acc) n_state = w_k_last ? S_IDLE : S_RDK;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= BASE_RESET;
            r_width <= WIDTH_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DIGIT_BASE: r_base  <= i_cfg_data[BASE_W-1:0];
                CFG_BIN_WIDTH:  r_width <= i_cfg_data[MZ_W-1:0];
                default: ;
            endcase
        end
    end

    // ion capture, bin index, digit counter, largest sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_largest <= '0;
            r_k       <= '0;
        end else begin
            if (r_state == S_ACC) begin
                if (w_sum > r_largest) r_largest <= w_sum;
                r_k <= '0;
            end
            if ((r_state == S_OUT) && w_out_acc) begin
                if (w_k_last) begin
                    r_largest <= '0;
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_inten <= s_axis_tdata[MZ_W +: INT_W];
            r_last  <= s_axis_tlast;
        end
        if ((r_state == S_BIN) && w_done) r_idx <= w_mod;
        if (r_state == S_MUL) r_prod <= PROD_W'(w_scale) * PROD_W'(w_rd_eff);
        if (r_state == S_DSTART) r_digit <= '0;
        if ((r_state == S_DWAIT) && w_done) r_digit <= w_quot;
    end

    // bin store: one read address, one write address
    assign w_rd_addr = (r_state == S_BIN) ? w_mod : r_k;

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[w_rd_addr];
        if (r_state == S_ACC) begin
            r_mem[r_idx] <= w_sum;
        end else if (r_state == S_MUL) begin
            r_mem[r_k] <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= r_valid[w_rd_addr];
            if (r_state == S_ACC) begin
                r_valid[r_idx] <= 1'b1;
            end else if (r_state == S_MUL) begin
                r_valid[r_k] <= 1'b0;
            end
        end
    end

    // ports
    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {(OUT_DATA_W-DIGIT_W-NUM_W)'(0), NUM_W'(r_k), r_digit};
    assign m_axis_tlast  = w_k_last;

endmodule

`default_nettype wire

// ===== design/whd_div.sv =====
// ----------------------------------------------------------------------------
// whd_div - shared restoring divider
// One quotient bit per cycle, MSB first. Keeps a running quotient mod
// BIN_COUNT and the low quotient bits for digit results.
// ----------------------------------------------------------------------------
`default_nettype none

module whd_div
    import whd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_div_req              i_req,
    input  wire logic [SUM_W-1:0]      i_rem_init,  // partial remainder, below divisor
    input  wire logic [DIV_BITS_W-1:0] i_bits,      // remaining dividend bits, MSB first
    input  wire logic [SUM_W-1:0]      i_divisor,
    output logic                       o_done,
    output logic [QUOT_W-1:0]          o_quot,
    output logic [BIN_W-1:0]           o_mod
);

    logic                  r_busy;
    logic [CNT_W-1:0]      r_cnt;
    logic [SUM_W-1:0]      r_rem;
    logic [DIV_BITS_W-1:0] r_bits;
    logic [SUM_W-1:0]      r_div;
    logic [QUOT_W-1:0]     r_quot;
    logic [BIN_W-1:0]      r_mod;
    logic                  r_done;

    logic [SUM_W:0]        w_trial;
    logic                  w_ge;
    logic [SUM_W:0]        w_diff;
    logic [BIN_W:0]        w_mod2;
    logic [BIN_W:0]        w_mod_nx;

    // one restoring step
    always_comb begin
        w_trial = {r_rem, r_bits[DIV_BITS_W-1]};
        w_ge    = (w_trial >= {1'b0, r_div});
        w_diff  = w_trial - {1'b0, r_div};
        w_mod2  = {r_mod, w_ge};
        if (w_mod2 >= (BIN_W+1)'(BIN_COUNT)) begin
            w_mod_nx = w_mod2 - (BIN_W+1)'(BIN_COUNT);
        end else begin
            w_mod_nx = w_mod2;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.count;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_rem_init;
            r_bits <= i_bits;
            r_div  <= i_divisor;
            r_quot <= '0;
            r_mod  <= '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[SUM_W-1:0] : w_trial[SUM_W-1:0];
            r_bits <= {r_bits[DIV_BITS_W-2:0], 1'b0};
            r_quot <= {r_quot[QUOT_W-2:0], w_ge};
            r_mod  <= w_mod_nx[BIN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_mod  = r_mod;

endmodule

`default_nettype wire

// ===== tb/wrapped_bin_histogram_digits_tb.sv =====
// ----------------------------------------------------------------------------
// wrapped_bin_histogram_digits_tb - self-checking bench for the histogram
// Streams ion beats into the block and checks every digit beat against a
// cycle-free copy of the wrapped histogram kept in the bench. A short
// directed run covers the register extremes and the empty histogram, then
// random spectra run under several register settings with random sender
// bursts and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module wrapped_bin_histogram_digits_tb;
    import whd_pkg::*;

    localparam int RANDOM_IONS   = 350;
    localparam int SETTLE_CYCLES = 120;
    localparam int END_CYCLES    = 200;
    localparam int RUN_LIMIT     = 4000000;

    // register indexes that decode to nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef enum logic [1:0] {
        PLAN_ION,
        PLAN_CFG,
        PLAN_DRAIN
    } plan_kind_e;

    typedef struct {
        plan_kind_e            kind;
        logic [MZ_W-1:0]       mz;
        logic [INT_W-1:0]      inten;
        logic                  last;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } plan_item_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic [NUM_W-1:0]   number;
        logic               last;
    } bin_digit_t;

    // dut connections
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // mz_micro[39:0], intensity_q[71:40]
    logic                  s_axis_tlast  = 1'b0; // last_ion
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // bin_digit[5:0], bin_number[11:6], pad
    logic                  m_axis_tlast;        // last_digit

    // stimulus plan and expected digits
    plan_item_t      plan_q[$];
    bin_digit_t      digit_q[$];
    int              digits_owed = 0;
    int              digits_got  = 0;
    int              fail_count  = 0;

    // histogram copy kept by the bench
    logic [BASE_W-1:0] model_base;
    logic [MZ_W-1:0]   model_width;
    logic [SUM_W-1:0]  hist_sums[BIN_COUNT];
    logic [SUM_W-1:0]  hist_peak;

    wrapped_bin_histogram_digits i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [MZ_W-1:0] rand_bits40();
        return MZ_W'({$urandom, $urandom});
    endfunction

    function automatic void add_ion(input logic [MZ_W-1:0] mz,
                                    input logic [INT_W-1:0] inten, input logic last);
        plan_item_t p;
        p = '{kind: PLAN_ION, mz: mz, inten: inten, last: last, idx: '0, data: '0};
        plan_q = {plan_q, p};
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
        plan_item_t p;
        p = '{kind: PLAN_CFG, mz: '0, inten: '0, last: 1'b0, idx: idx, data: data};
        plan_q = {plan_q, p};
    endfunction

    function automatic void add_drain();
        plan_item_t p;
        p = '{kind: PLAN_DRAIN, mz: '0, inten: '0, last: 1'b0, idx: '0, data: '0};
        plan_q = {plan_q, p};
    endfunction

    // m/z placed on chosen bins of the current width in a third of picks, else zero, all ones or anywhere
    function automatic logic [MZ_W-1:0] pick_mz(input logic [MZ_W-1:0] w);
        logic [63:0] w_eff;
        logic [63:0] mz64;
        w_eff = (w == '0) ? 64'd1 : 64'(w);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return rand_bits40();
            default: begin
                mz64 = w_eff * 64'($urandom_range(0, 30)) + ({$urandom, $urandom} % w_eff);
                return mz64[MZ_W-1:0];
            end
        endcase
    endfunction

    function automatic logic [INT_W-1:0] pick_intensity();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return INT_W'($urandom_range(0, 1000));
            default: return $urandom;
        endcase
    endfunction

    function automatic void set_model_reg(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_DIGIT_BASE: model_base  = data[BASE_W-1:0];
            CFG_BIN_WIDTH:  model_width = data[MZ_W-1:0];
            default: ;
        endcase
    endfunction

    // add one ion to its wrapped bin; on the last ion queue one digit per bin
    task automatic bin_ion(input logic [MZ_W-1:0] mz, input logic [INT_W-1:0] inten,
                           input logic last);
        logic [MZ_W-1:0]   w;
        logic [BIN_W-1:0]  slot;
        logic [SUM_W:0]    acc;
        logic [BASE_W-1:0] base;
        logic [63:0]       prod;
        bin_digit_t        d;
        int                k;
        w    = (model_width == '0) ? MZ_W'(1) : model_width;
        slot = BIN_W'((mz / w) % MZ_W'(BIN_COUNT));
        acc  = {1'b0, hist_sums[slot]} + (SUM_W+1)'(inten);
        hist_sums[slot] = acc[SUM_W] ? {SUM_W{1'b1}} : acc[SUM_W-1:0];
        if (hist_sums[slot] > hist_peak) hist_peak = hist_sums[slot];
        if (last) begin
            base = model_base;
            if (base < BASE_MIN) base = BASE_MIN;
            if (base > BASE_MAX) base = BASE_MAX;
            for (k = 0; k < BIN_COUNT; k++) begin
                prod     = 64'(base - BASE_W'(1)) * 64'(hist_sums[k]);
                d.digit  = (hist_peak == '0) ? '0 : DIGIT_W'(prod / 64'(hist_peak));
                d.number = NUM_W'(k);
                d.last   = (k == BIN_COUNT - 1);
                digit_q  = {digit_q, d};
            end
            digits_owed += BIN_COUNT;
            for (k = 0; k < BIN_COUNT; k++) hist_sums[k] = '0;
            hist_peak = '0;
        end
    endtask

    // sender: bursts of ion beats, register writes only once the block is idle
    always @(posedge i_clk) begin : drive_beats
        int         gap_left;
        int         burst_left;
        int         settle_left;
        logic       ion_free;
        logic       cfg_free;
        logic       drive_ion;
        logic       drive_cfg;
        plan_item_t p;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            i_cfg_valid   <= 1'b0;
            gap_left      = 0;
            burst_left    = 1;
            settle_left   = SETTLE_CYCLES;
            model_base    = BASE_RESET;
            model_width   = WIDTH_RESET;
            hist_peak     = '0;
            for (int k = 0; k < BIN_COUNT; k++) hist_sums[k] = '0;
        end else begin
            // beats that went through on this edge
            if (s_axis_tvalid && s_axis_tready) begin
                bin_ion(s_axis_tdata[MZ_W-1:0], s_axis_tdata[MZ_W+INT_W-1:MZ_W],
                        s_axis_tlast);
            end
            if (i_cfg_valid && o_cfg_ready) set_model_reg(i_cfg_index, i_cfg_data);

            // quiet time restarts while anything is in flight
            if (s_axis_tvalid || digits_owed != digits_got) begin
                settle_left = SETTLE_CYCLES;
            end else if (settle_left > 0) begin
                settle_left--;
            end

            ion_free = !s_axis_tvalid || s_axis_tready;
            cfg_free = !i_cfg_valid || o_cfg_ready;
            if (ion_free && cfg_free) begin
                drive_ion = 1'b0;
                drive_cfg = 1'b0;
                if (plan_q.size() != 0) begin
                    if (plan_q[0].kind == PLAN_ION) begin
                        if (gap_left > 0) begin
                            gap_left--;
                        end else begin
                            p = plan_q.pop_front();
                            s_axis_tdata <= {p.inten, p.mz};
                            s_axis_tlast <= p.last;
                            drive_ion = 1'b1;
                            burst_left--;
                            if (burst_left == 0) begin
                                burst_left = $urandom_range(1, 8);
                                gap_left = ($urandom_range(0, 2) == 0) ? 0
                                           : $urandom_range(1, 60);
                            end
                        end
                    end else if (settle_left == 0) begin
                        p = plan_q.pop_front();
                        if (p.kind == PLAN_CFG) begin
                            i_cfg_index <= p.idx;
                            i_cfg_data  <= p.data;
                            drive_cfg = 1'b1;
                        end
                    end
                end
                s_axis_tvalid <= drive_ion;
                i_cfg_valid   <= drive_cfg;
            end
        end
    end

    // receiver: ready follows a 16-bit pattern that is redrawn each time the 6-bit tick wraps
    always @(posedge i_clk) begin : stall_digits
        logic [5:0]  tick;
        logic [15:0] pattern;
        if (tick === 6'bx) tick = '0;
        if (tick == '0) begin
            case ($urandom_range(0, 3))
                0:       pattern = '1;
                1:       pattern = 16'h0001;
                default: pattern = 16'($urandom) | 16'h0001;
            endcase
        end
        m_axis_tready <= pattern[tick[3:0]];
        tick = tick + 6'd1;
    end

    // check every digit beat against the oldest expected digit
    always @(posedge i_clk) begin : check_digits
        bin_digit_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (digit_q.size() == 0) begin
                $error("digit beat with no digit expected: tdata %h tlast %b",
                       m_axis_tdata, m_axis_tlast);
                fail_count++;
            end else begin
                want = digit_q.pop_front();
                digits_got <= digits_got + 1;
                if (m_axis_tdata[DIGIT_W-1:0] !== want.digit) begin
                    $error("bin_digit: expected %0d, got %0d", want.digit,
                           m_axis_tdata[DIGIT_W-1:0]);
                    fail_count++;
                end
                if (m_axis_tdata[DIGIT_W+NUM_W-1:DIGIT_W] !== want.number) begin
                    $error("bin_number: expected %0d, got %0d", want.number,
                           m_axis_tdata[DIGIT_W+NUM_W-1:DIGIT_W]);
                    fail_count++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last_digit: expected %0d, got %0d", want.last, m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    // stimulus plan, reset and end of run
    initial begin : run
        int              ions_left;
        int              span;
        int              k;
        logic            empty;
        logic [MZ_W-1:0] w;

        // empty histogram under reset settings
        add_ion('0, '0, 1'b1);
        // field extremes under reset settings
        add_ion('1, '1, 1'b0);
        add_ion(40'd250000000, 32'd1, 1'b0);
        add_ion(40'd950000000, 32'h0000_8000, 1'b1);
        // base below range and zero width
        add_cfg(CFG_DIGIT_BASE, '0);
        add_cfg(CFG_BIN_WIDTH, '0);
        add_ion(40'd3, 32'd100, 1'b0);
        add_ion(40'd14, 32'd40, 1'b0);
        add_ion(40'd29, 32'd100, 1'b1);
        // base above range and widest bins
        add_cfg(CFG_DIGIT_BASE, 40'd63);
        add_cfg(CFG_BIN_WIDTH, '1);
        add_ion('1, '1, 1'b0);
        add_ion('0, 32'd12345, 1'b1);
        // writes to unused indexes leave the registers alone
        add_cfg(CFG_SPARE_A, '1);
        add_cfg(CFG_SPARE_B, '1);
        // upper data bits of the base write are dropped
        add_cfg(CFG_DIGIT_BASE, 40'hFF_FFFF_FFE5);
        add_cfg(CFG_BIN_WIDTH, 40'd1);
        add_ion(40'd7, '1, 1'b0);
        add_ion(40'd17, '1, 1'b0);
        add_ion(40'd8, 32'd1, 1'b1);
        add_cfg(CFG_DIGIT_BASE, 40'd36);
        add_cfg(CFG_BIN_WIDTH, 40'(WIDTH_RESET));

        // random spectra, a fresh register setting per phase
        ions_left = RANDOM_IONS;
        while (ions_left > 0) begin
            case ($urandom_range(0, 5))
                0:       w = MZ_W'(1);
                1:       w = '1;
                2:       w = MZ_W'($urandom_range(1, 2000));
                3:       w = WIDTH_RESET;
                4:       w = rand_bits40();
                default: w = '0;
            endcase
            add_cfg(CFG_BIN_WIDTH, w);
            case ($urandom_range(0, 3))
                0:       add_cfg(CFG_DIGIT_BASE, {34'($urandom), 6'($urandom)});
                1:       add_cfg(CFG_DIGIT_BASE, ($urandom_range(0, 1) == 0) ? 40'd2 : 40'd36);
                default: add_cfg(CFG_DIGIT_BASE,
                                 {34'($urandom), 6'($urandom_range(2, 36))});
            endcase
            if ($urandom_range(0, 5) == 0) begin
                add_cfg(($urandom_range(0, 1) == 0) ? CFG_SPARE_A : CFG_SPARE_B,
                        rand_bits40());
            end
            repeat ($urandom_range(3, 6)) begin
                span  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                        : $urandom_range(1, 10);
                empty = ($urandom_range(0, 9) == 0);
                for (k = 0; k < span; k++) begin
                    add_ion(pick_mz(w), empty ? '0 : pick_intensity(), k == span - 1);
                    ions_left--;
                    // sender holds off until the block has gone quiet
                    if (k != span - 1 && $urandom_range(0, 19) == 0) add_drain();
                end
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (plan_q.size() == 0 && !s_axis_tvalid && !i_cfg_valid);
        wait (digits_owed == digits_got);
        repeat (END_CYCLES) @(posedge i_clk);
        if (digit_q.size() != 0) begin
            $error("%0d expected digits never arrived", digit_q.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // hard stop for a hung block
    initial begin : watchdog
        #RUN_LIMIT;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
